FILE: rtl/lmb_pkg.sv
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared constants for the LED mode blinker: field widths, action, mode and
// register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lmb_pkg;

  localparam int unsigned PERIOD_BITS   = 16;
  localparam int unsigned DURATION_BITS = 32;

  // action codes (carried in s_axis_tuser)
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_SHOT = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_SLOW = 2'd2;
  localparam logic [1:0] MODE_FAST = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_ACTIVE = 2'd1;
  localparam logic [1:0] REG_SLOW   = 2'd2;
  localparam logic [1:0] REG_FAST   = 2'd3;

  localparam logic [PERIOD_BITS-1:0] SLOW_DEFAULT = PERIOD_BITS'(750);
  localparam logic [PERIOD_BITS-1:0] FAST_DEFAULT = PERIOD_BITS'(250);

  localparam int unsigned IN_DATA_BITS  = 40;  // 2 + 32 used, padded to bytes
  localparam int unsigned OUT_DATA_BITS = 8;   // 4 used, padded to a byte

endpackage

`default_nettype wire

FILE: rtl/led_mode_blinker.sv
// ----------------------------------------------------------------------------
// led_mode_blinker
// LED driver with off, on, slow blink and fast blink modes plus a one-shot
// lit override, driven by a stream of tick, mode and one-shot words.
// ----------------------------------------------------------------------------
// Each input word is a one millisecond tick, a mode command or a one-shot
// request, chosen by s_axis_tuser. Exactly one result word comes out per
// input word, in the cycle after acceptance, carrying the pin level (polarity
// applied), the current mode and the one-shot flag. The block takes one word
// per clock: the whole state update is a single registered pass of counter
// increments and compares, and the result register reloads in the same cycle
// its word is taken, so words flow back to back while m_axis_tready stays
// high; a result left waiting holds off the input until it is taken. A blink
// mode starts dark and toggles after its half period of ticks; a one-shot
// lights the LED for the given ticks, freezes blink timing meanwhile, and then
// re-applies the current mode. A mode command cancels any one-shot. While the
// enable register is zero every word is ignored and the pin shows the unlit
// level. Write configuration only while no result is outstanding.
`default_nettype none

module led_mode_blinker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [lmb_pkg::PERIOD_BITS-1:0]   cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [1:0] mode, [33:2] blink_duration, rest zero
  input  wire logic [lmb_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]                        s_axis_tuser,
  // result stream
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] pin_level, [2:1] mode_now, [3] one_shot_active, rest zero
  output      logic [lmb_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int unsigned PB = lmb_pkg::PERIOD_BITS;
  localparam int unsigned DB = lmb_pkg::DURATION_BITS;

  // configuration registers
  logic          enable_q;
  logic          active_high_q;
  logic [PB-1:0] slow_half_q;
  logic [PB-1:0] fast_half_q;

  // blinker state
  logic [1:0]    mode_q,    mode_d;
  logic          phase_q,   phase_d;
  logic [PB-1:0] blink_q,   blink_d;
  logic          shot_q,    shot_d;
  logic [DB-1:0] shot_el_q, shot_el_d;
  logic [DB-1:0] shot_len_q, shot_len_d;
  logic          lit_q,     lit_d;

  // result register
  logic          out_valid_q;
  logic [3:0]    out_q, out_d;

  logic          in_acc;
  logic [1:0]    in_mode;
  logic [DB-1:0] in_dur;
  logic [PB-1:0] half;
  logic [PB-1:0] blink_inc;
  logic [DB-1:0] shot_inc;
  logic          lit_out;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tdata[1:0];
  assign in_dur        = s_axis_tdata[DB+1:2];

  assign half      = (mode_q == lmb_pkg::MODE_SLOW) ? slow_half_q : fast_half_q;
  // saturate both counters at all ones
  assign blink_inc = (&blink_q) ? blink_q : blink_q + PB'(1);
  assign shot_inc  = (&shot_el_q) ? shot_el_q : shot_el_q + DB'(1);

  always_comb begin
    mode_d     = mode_q;
    phase_d    = phase_q;
    blink_d    = blink_q;
    shot_d     = shot_q;
    shot_el_d  = shot_el_q;
    shot_len_d = shot_len_q;
    lit_d      = lit_q;

    if (enable_q) begin
      case (s_axis_tuser)
        lmb_pkg::ACT_TICK: begin
          if (shot_q) begin
            // advance the one-shot, re-apply the mode when it runs out
            shot_el_d = shot_inc;
            if (shot_inc >= shot_len_q) begin
              shot_d = 1'b0;
              case (mode_q)
                lmb_pkg::MODE_ON:  lit_d = 1'b1;
                lmb_pkg::MODE_OFF: lit_d = 1'b0;
                default: begin
                  phase_d = 1'b0;
                  blink_d = '0;
                  lit_d   = 1'b0;
                end
              endcase
            end
          end else if (mode_q == lmb_pkg::MODE_SLOW || mode_q == lmb_pkg::MODE_FAST) begin
            blink_d = blink_inc;
            if (blink_inc >= half) begin
              blink_d = '0;
              phase_d = !phase_q;
              lit_d   = !phase_q;
            end
          end
        end
        lmb_pkg::ACT_SET: begin
          shot_d = 1'b0;
          if (in_mode != mode_q || shot_q) begin
            mode_d = in_mode;
            case (in_mode)
              lmb_pkg::MODE_ON:  lit_d = 1'b1;
              lmb_pkg::MODE_OFF: lit_d = 1'b0;
              default: begin
                phase_d = 1'b0;
                blink_d = '0;
                lit_d   = 1'b0;
              end
            endcase
          end
        end
        lmb_pkg::ACT_SHOT: begin
          shot_d     = 1'b1;
          shot_el_d  = '0;
          shot_len_d = in_dur;
          lit_d      = 1'b1;
        end
        default: ;  // unused action: drop
      endcase
    end

    lit_out = enable_q && lit_d;
    out_d   = {shot_d, mode_d, lit_out ? active_high_q : !active_high_q};
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      active_high_q <= 1'b1;
      slow_half_q   <= lmb_pkg::SLOW_DEFAULT;
      fast_half_q   <= lmb_pkg::FAST_DEFAULT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lmb_pkg::REG_ENABLE: enable_q      <= cfg_data_i[0];
        lmb_pkg::REG_ACTIVE: active_high_q <= cfg_data_i[0];
        lmb_pkg::REG_SLOW:   slow_half_q   <= cfg_data_i;
        lmb_pkg::REG_FAST:   fast_half_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state update, one word per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= lmb_pkg::MODE_OFF;
      phase_q    <= 1'b0;
      blink_q    <= '0;
      shot_q     <= 1'b0;
      shot_el_q  <= '0;
      shot_len_q <= '0;
      lit_q      <= 1'b0;
    end else if (in_acc) begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      blink_q    <= blink_d;
      shot_q     <= shot_d;
      shot_el_q  <= shot_el_d;
      shot_len_q <= shot_len_d;
      lit_q      <= lit_d;
    end
  end

  // result register: load on accept, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(lmb_pkg::OUT_DATA_BITS-4){1'b0}}, out_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_set_cancels_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && enable_q && s_axis_tuser == lmb_pkg::ACT_SET |=> !shot_q)
    else $error("mode command left a one-shot running");

  a_shot_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && enable_q && s_axis_tuser == lmb_pkg::ACT_SHOT |=> shot_q && lit_q)
    else $error("one-shot request did not light the led");

  a_disabled_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !enable_q |=> $stable(mode_q) && $stable(lit_q) && $stable(shot_q))
    else $error("state changed while disabled");

  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !in_acc)
    else $error("item accepted over a pending result");

endmodule

`default_nettype wire

FILE: tb/sv/led_mode_blinker_tb.sv
// ----------------------------------------------------------------------------
// led_mode_blinker_tb
// Self-checking testbench for the LED mode blinker. Words go in on the input
// stream and the pin level, mode and one-shot flag that each one should
// produce are worked out alongside. Every status word that comes back is
// checked against the oldest one still due. A short directed run covers the
// modes, the one-shot cases and disabled operation. Several randomized phases
// with different register settings and random stalls on both streams follow.
// ----------------------------------------------------------------------------

import lmb_pkg::*;

class led_pin_tracker;
  // register copies
  bit               enabled;
  bit               lit_level;
  logic [15:0]      slow_half;
  logic [15:0]      fast_half;
  // blinker state
  logic [1:0]       cur_mode;
  bit               phase_lit;
  logic [15:0]      blink_count;
  bit               shot_on;
  logic [31:0]      shot_count;
  logic [31:0]      shot_len;
  bit               lit;
  // status words still owed by the block: [0] pin, [2:1] mode, [3] one-shot
  logic [7:0]       status_due[$];
  int               errors;

  function new();
    enabled     = 1'b0;
    lit_level   = 1'b1;
    slow_half   = SLOW_DEFAULT;
    fast_half   = FAST_DEFAULT;
    cur_mode    = MODE_OFF;
    phase_lit   = 1'b0;
    blink_count = '0;
    shot_on     = 1'b0;
    shot_count  = '0;
    shot_len    = '0;
    lit         = 1'b0;
    errors      = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_ENABLE: enabled   = val[0];
      REG_ACTIVE: lit_level = val[0];
      REG_SLOW:   slow_half = val;
      REG_FAST:   fast_half = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return status_due.size();
  endfunction

  function void restart_mode();
    if (cur_mode == MODE_ON) begin
      lit = 1'b1;
    end else if (cur_mode == MODE_OFF) begin
      lit = 1'b0;
    end else begin
      phase_lit   = 1'b0;
      blink_count = '0;
      lit         = 1'b0;
    end
  endfunction

  function void advance_tick();
    logic [15:0] half;
    if (shot_on) begin
      if (shot_count != '1) shot_count++;
      if (shot_count >= shot_len) begin
        shot_on = 1'b0;
        restart_mode();
      end
    end else if (cur_mode == MODE_SLOW || cur_mode == MODE_FAST) begin
      half = (cur_mode == MODE_SLOW) ? slow_half : fast_half;
      if (blink_count != '1) blink_count++;
      if (blink_count >= half) begin
        blink_count = '0;
        phase_lit   = ~phase_lit;
        lit         = phase_lit;
      end
    end
  endfunction

  function void note_word(logic [1:0] act, logic [1:0] md, logic [31:0] dur);
    bit was_shot;
    bit pin;
    if (enabled) begin
      case (act)
        ACT_TICK: advance_tick();
        ACT_SET: begin
          was_shot = shot_on;
          shot_on  = 1'b0;
          if (md != cur_mode || was_shot) begin
            cur_mode = md;
            restart_mode();
          end
        end
        ACT_SHOT: begin
          shot_on    = 1'b1;
          shot_count = '0;
          shot_len   = dur;
          lit        = 1'b1;
        end
        default: ;
      endcase
    end
    pin = (enabled && lit) ? lit_level : ~lit_level;
    status_due.push_back({4'b0000, shot_on, cur_mode, pin});
  endfunction

  function void check_word(logic [7:0] got);
    logic [7:0] want;
    if (status_due.size() == 0) begin
      $display("%0t: status word %h arrived with none due", $time, got);
      errors++;
    end else begin
      want = status_due.pop_front();
      if (got[0] !== want[0]) begin
        $display("%0t: pin_level expected %b actual %b", $time, want[0], got[0]);
        errors++;
      end
      if (got[2:1] !== want[2:1]) begin
        $display("%0t: mode_now expected %0d actual %0d", $time, want[2:1], got[2:1]);
        errors++;
      end
      if (got[3] !== want[3]) begin
        $display("%0t: one_shot_active expected %b actual %b", $time, want[3], got[3]);
        errors++;
      end
      if (got[7:4] !== want[7:4]) begin
        $display("%0t: padding expected %h actual %h", $time, want[7:4], got[7:4]);
        errors++;
      end
    end
  endfunction
endclass

module led_mode_blinker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CLK_PERIOD  = 10;
  localparam int         PHASES      = 8;
  localparam int         PHASE_WORDS = 215;
  localparam int         QUIET_LIMIT = 2000;  // several times the longest hold-off
  localparam int         HOLD_CYCLES = 300;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i;
  logic [PERIOD_BITS-1:0]   cfg_data_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;   // [1:0] mode, [33:2] blink_duration
  logic [1:0]               s_axis_tuser;   // [1:0] action
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;   // [0] pin, [2:1] mode, [3] one-shot

  // idling odds in percent per decision, set per phase
  int gap_pct   = 0;
  int stall_pct = 0;
  // the main flow raises this to ask the receiver for one long hold-off
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;

  led_pin_tracker pins = new();

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  led_mode_blinker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Result side: check each accepted status word, then pick the next ready
  // level. A pending long hold-off wins over random bursts.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      pins.check_word(m_axis_tdata);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(1, 100) <= stall_pct) begin
      stall_left = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: give up once nothing has moved on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one word and hold it until taken. Leave tvalid high so the next
  // word can follow back to back.
  task automatic send_word(input logic [1:0] act, input logic [1:0] md,
                           input logic [31:0] dur);
    int gap;
    if ($urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, dur, md};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    pins.note_word(act, md, dur);
  endtask

  // Write one register; valid stays high for the next write.
  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    pins.write_reg(idx, val);
  endtask

  task automatic configure(input bit en, input bit act_hi, input logic [15:0] slow,
                           input logic [15:0] fast);
    put_reg(REG_ENABLE, {15'd0, en});
    put_reg(REG_ACTIVE, {15'd0, act_hi});
    put_reg(REG_SLOW, slow);
    put_reg(REG_FAST, fast);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop the input and wait for every owed status word, then settle.
  task automatic drain(input int settle);
    s_axis_tvalid <= 1'b0;
    while (pins.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Mostly short half periods so blinking actually toggles.
  function automatic logic [15:0] random_half();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 12));
  endfunction

  // Tick-heavy mix so that one-shots run out and blink phases turn over.
  task automatic send_random_word();
    logic [1:0]  act;
    logic [31:0] dur;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      act = ACT_TICK;
    else if (pick < 75) act = ACT_SET;
    else if (pick < 93) act = ACT_SHOT;
    else                act = ACT_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 7)      dur = $urandom_range(0, 15);
    else if (pick < 9) dur = $urandom_range(16, 300);
    else               dur = $urandom();
    send_word(act, 2'($urandom_range(0, 3)), dur);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_ENABLE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_TICK;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disabled after reset: every word is ignored, pin shows the unlit level.
    send_word(ACT_SET, MODE_ON, 32'd0);
    send_word(ACT_SHOT, MODE_FAST, 32'd7);
    send_word(ACT_TICK, MODE_SLOW, 32'd0);
    send_word(ACT_UNUSED, MODE_ON, 32'hFFFF_FFFF);
    drain(4);

    // Enable; fast blink with a zero half period toggles on every tick.
    configure(1'b1, 1'b1, 16'd4, 16'd0);
    send_word(ACT_SET, MODE_ON, 32'd0);
    send_word(ACT_SET, MODE_OFF, 32'd0);
    send_word(ACT_SET, MODE_SLOW, 32'd0);
    repeat (4) send_word(ACT_TICK, MODE_OFF, 32'd0);   // lights on the fourth
    send_word(ACT_SET, MODE_SLOW, 32'd0);              // same mode, nothing moves
    send_word(ACT_TICK, MODE_OFF, 32'd0);
    send_word(ACT_SHOT, MODE_OFF, 32'd0);              // zero length shot
    send_word(ACT_TICK, MODE_OFF, 32'd0);              // ends it, slow restarts dark
    send_word(ACT_SHOT, MODE_OFF, 32'd2);
    send_word(ACT_TICK, MODE_OFF, 32'd0);
    send_word(ACT_SET, MODE_FAST, 32'd0);              // cancel the shot
    repeat (2) send_word(ACT_TICK, MODE_OFF, 32'd0);
    send_word(ACT_SHOT, MODE_OFF, 32'd3);
    send_word(ACT_SHOT, MODE_OFF, 32'd1);              // restart while active
    send_word(ACT_TICK, MODE_OFF, 32'd0);
    send_word(ACT_UNUSED, MODE_SLOW, 32'd5);
    send_word(ACT_SHOT, MODE_OFF, 32'hFFFF_FFFF);
    send_word(ACT_SET, MODE_FAST, 32'd0);              // same mode still re-applies
    send_word(ACT_SET, MODE_SLOW, 32'd0);
    repeat (2) send_word(ACT_TICK, MODE_OFF, 32'd0);   // count sits at two
    drain(4);

    // Lower the slow half period under the running count, flip polarity.
    configure(1'b1, 1'b0, 16'd1, 16'hFFFF);
    repeat (2) send_word(ACT_TICK, MODE_OFF, 32'd0);
    drain(4);

    // Randomized phases: fixed extremes first, then a disabled stretch,
    // then random settings. The fifth phase carries the long hold-off and
    // the last one runs without any idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       configure(1'b1, 1'b1, 16'd1, 16'd2);
        1:       configure(1'b1, 1'b0, 16'd0, 16'hFFFF);
        2:       configure(1'b0, 1'($urandom_range(0, 1)), random_half(), random_half());
        default: configure(1'b1, 1'($urandom_range(0, 1)), random_half(), random_half());
      endcase
      gap_pct   = (p == PHASES - 1 || p == 4) ? 0 : $urandom_range(0, 2) * 15;
      stall_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 2) * 15;
      if (p == 4) hold_request = 1'b1;
      repeat ((p == 2) ? 60 : PHASE_WORDS) send_random_word();
      drain(4);
    end

    drain(10);
    if (pins.errors == 0 && pins.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d status words never arrived", pins.errors,
               pins.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lmb_pkg.sv
rtl/led_mode_blinker.sv
tb/sv/led_mode_blinker_tb.sv
